// ===== design/cnr_pkg.sv =====
`timescale 1ns / 1ps

package cnr_pkg;

  localparam int MaxChars  = 5;
  localparam int SlotBits  = $clog2(MaxChars);
  localparam int QueueDepth = 2;

  localparam logic [15:0] CodeLing = 16'hC1E3;
  localparam logic [15:0] CodeShi  = 16'hCAAE;
  localparam logic [15:0] CodeBai  = 16'hB0D9;

  // what one output character stands for; digits are resolved in the back part
  typedef enum logic [2:0] {
    SYM_LING = 3'd0,
    SYM_HUND = 3'd1,
    SYM_TENS = 3'd2,
    SYM_UNIT = 3'd3,
    SYM_SHI  = 3'd4,
    SYM_BAI  = 3'd5
  } cnr_sym_t;

  typedef struct packed {
    logic [1:0]                   hund;
    logic [3:0]                   tens;
    logic [3:0]                   unit;
    cnr_sym_t [MaxChars-1:0]      syms;
    logic [SlotBits-1:0]          cnt;
  } cnr_item_t;

  function automatic logic [15:0] digit_code(input logic [3:0] d);
    logic [15:0] c;
    case (d)
      4'd0:    c = 16'hC1E3;
      4'd1:    c = 16'hD2BB;
      4'd2:    c = 16'hB6FE;
      4'd3:    c = 16'hC8FD;
      4'd4:    c = 16'hCBC4;
      4'd5:    c = 16'hCEE5;
      4'd6:    c = 16'hC1F9;
      4'd7:    c = 16'hC6DF;
      4'd8:    c = 16'hB0CB;
      4'd9:    c = 16'hBEC5;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] sym_code(input cnr_sym_t s, input cnr_item_t it);
    logic [15:0] c;
    case (s)
      SYM_LING: c = CodeLing;
      SYM_HUND: c = digit_code({2'b00, it.hund});
      SYM_TENS: c = digit_code(it.tens);
      SYM_UNIT: c = digit_code(it.unit);
      SYM_SHI:  c = CodeShi;
      SYM_BAI:  c = CodeBai;
      default:  c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

// ===== design/number_to_chinese_numeral_top.sv =====
`timescale 1ns / 1ps

// Reads an 8-bit number out as a spoken Chinese numeral in GB2312 codes, one
// 16-bit character per output transfer with tlast on the final character of
// the run. A number yields 1 to 5 characters; the output port emitting one
// character per cycle, unless m_tready holds it back, sets the
// sustained rate. The input side classifies a request in the cycle it is
// taken and parks it in a two-entry queue, so a new number is accepted every
// cycle while the queue has room, independent of the output stalling.
module number_to_chinese_numeral_top import cnr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] number
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] char_code
  output logic        m_tlast
);

  cnr_item_t front_item;
  cnr_item_t head;
  logic      full;
  logic      not_empty;
  logic      push;
  logic      pop;

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  cnr_front u_front (
    .number (s_tdata),
    .item   (front_item)
  );

  cnr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  cnr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (not_empty),
    .q_item   (head),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== design/cnr_front.sv =====
`timescale 1ns / 1ps

module cnr_front import cnr_pkg::*; (
  input  logic [7:0] number,
  output cnr_item_t  item
);

  logic [1:0]          hund;
  logic [6:0]          rem;
  logic [14:0]         prod;
  logic [3:0]          tens;
  logic [6:0]          tens_x10;
  logic [6:0]          unit_w;
  logic [3:0]          unit;
  cnr_sym_t            slots [MaxChars];
  logic [SlotBits-1:0] n;

  always_comb begin
    if (number >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(number - 8'd200);
    end else if (number >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(number - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = number[6:0];
    end
  end

  // divide by ten via reciprocal, exact for values below 100
  assign prod     = 15'(rem) * 15'd205;
  assign tens     = prod[14:11];
  assign tens_x10 = {tens, 3'b000} - 7'({tens, 1'b0}) + 7'({tens, 1'b0}) * 7'd2;
  assign unit_w   = rem - tens_x10;
  assign unit     = unit_w[3:0];

  always_comb begin
    for (int i = 0; i < MaxChars; i++) slots[i] = SYM_LING;
    n = '0;
    if (number == 8'd0) begin
      slots[n] = SYM_LING;
      n = n + 1'b1;
    end else begin
      if (hund != 2'd0) begin
        slots[n] = SYM_HUND;
        n = n + 1'b1;
        slots[n] = SYM_BAI;
        n = n + 1'b1;
        if (rem != 7'd0 && tens == 4'd0) begin
          slots[n] = SYM_LING;
          n = n + 1'b1;
        end
      end
      if (rem != 7'd0) begin
        if (tens >= 4'd2) begin
          slots[n] = SYM_TENS;
          n = n + 1'b1;
          slots[n] = SYM_SHI;
          n = n + 1'b1;
        end else if (tens == 4'd1) begin
          slots[n] = SYM_SHI;
          n = n + 1'b1;
        end
        if (unit != 4'd0 || tens == 4'd0) begin
          slots[n] = SYM_UNIT;
          n = n + 1'b1;
        end
      end
    end
  end

  always_comb begin
    item.hund = hund;
    item.tens = tens;
    item.unit = unit;
    item.cnt  = n;
    for (int i = 0; i < MaxChars; i++) item.syms[i] = slots[i];
  end

endmodule

// ===== design/cnr_queue.sv =====
`timescale 1ns / 1ps

module cnr_queue import cnr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cnr_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output cnr_item_t head
);

  localparam int PtrBits = $clog2(QueueDepth);

  cnr_item_t            mem [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [PtrBits:0]     count;

  assign full      = (count == (PtrBits+1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !not_empty |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    count <= (PtrBits+1)'(QueueDepth))
    else $error("queue count overflow");

endmodule

// ===== design/cnr_back.sv =====
`timescale 1ns / 1ps

module cnr_back import cnr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cnr_item_t   q_item,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tlast
);

  logic [SlotBits-1:0] k;
  logic                load;
  logic                is_last;
  cnr_sym_t            cur_sym;

  assign load    = q_valid && (!m_tvalid || m_tready);
  assign cur_sym = q_item.syms[k];
  assign is_last = (k == q_item.cnt - 1'b1);
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      k        <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        k        <= is_last ? '0 : k + 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= sym_code(cur_sym, q_item);
      m_tlast <= is_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_valid |-> k < q_item.cnt)
    else $error("slot index past end of run");
  assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_item.cnt >= 1 && q_item.cnt <= MaxChars))
    else $error("run length out of range");
  assert property (@(posedge clk) disable iff (rst) q_pop |=> k == '0)
    else $error("slot index not rewound after run");

endmodule

// ===== tb/sv/number_to_chinese_numeral_top_tb.sv =====
`timescale 1ns / 1ps

module number_to_chinese_numeral_top_tb import cnr_pkg::*;;

  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } glyph_t;

  localparam logic [15:0] DigitGlyph [10] = '{
    16'hC1E3, 16'hD2BB, 16'hB6FE, 16'hC8FD, 16'hCBC4,
    16'hCEE5, 16'hC1F9, 16'hC6DF, 16'hB0CB, 16'hBEC5
  };
  localparam int TailItems = 25;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  logic [7:0] pending_numbers [$];
  glyph_t     expected_chars [$];
  int         error_count = 0;
  int         send_gap = 0;
  int         recv_gap = 0;
  logic       bursty = 1'b1;
  logic       in_tail = 1'b0;

  number_to_chinese_numeral_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // reading of 1..99, or of the remainder after the hundreds
  function automatic void add_tens(ref logic [15:0] run [$], input int v);
    int tens;
    int unit;
    tens = (v / 10) % 10;
    unit = v % 10;
    if (tens >= 2) begin
      run.push_back(DigitGlyph[tens]);
      run.push_back(CodeShi);
    end else if (tens == 1) begin
      run.push_back(CodeShi);
    end
    if (unit != 0 || tens == 0) run.push_back(DigitGlyph[unit]);
  endfunction

  task automatic read_out_number(input logic [7:0] num);
    logic [15:0] run [$];
    int rem;
    glyph_t g;
    rem = int'(num) % 100;
    if (num == 8'd0) begin
      run.push_back(CodeLing);
    end else if (num >= 8'd100) begin
      run.push_back(DigitGlyph[int'(num) / 100]);
      run.push_back(CodeBai);
      if (rem != 0) begin
        if (rem < 10) run.push_back(CodeLing);
        add_tens(run, rem);
      end
    end else begin
      add_tens(run, int'(num));
    end
    foreach (run[k]) begin
      g.code = run[k];
      g.last = (k == run.size() - 1);
      expected_chars.push_back(g);
    end
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // switches between bursty and steady stretches, quiet for the tail
  always @(posedge clk) begin
    if ($urandom_range(0, 59) == 0) bursty <= ~bursty;
    in_tail <= (pending_numbers.size() <= TailItems);
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
    end else begin
      if (s_tvalid && s_tready) read_out_number(s_tdata);
      if (s_tvalid && !s_tready) begin
        // hold the request until it is taken
      end else if (send_gap != 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom);
      end else if (pending_numbers.size() != 0 && bursty && !in_tail &&
                   $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 13) - 1;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom);
      end else if (pending_numbers.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_numbers.pop_front();
      end else begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom);
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    glyph_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %h last %b", m_tdata, m_tlast));
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata !== want.code)
            report_mismatch($sformatf("char %h, want %h", m_tdata, want.code));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b (char %h)", m_tlast, want.last,
                                      want.code));
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if (bursty && !in_tail && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(1, 13) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] edge_numbers [$];
    int sel;
    edge_numbers = '{8'd0, 8'd1, 8'd9, 8'd10, 8'd11, 8'd19, 8'd20, 8'd21, 8'd99,
                     8'd100, 8'd101, 8'd109, 8'd110, 8'd111, 8'd119, 8'd120,
                     8'd121, 8'd199, 8'd200, 8'd205, 8'd210, 8'd250, 8'd255,
                     8'd170, 8'd85};
    foreach (edge_numbers[i]) pending_numbers.push_back(edge_numbers[i]);
    for (int i = 0; i < 145; i++) begin
      sel = $urandom_range(0, 3);
      if (sel == 0)
        // hundreds with a small or teen remainder
        pending_numbers.push_back(8'($urandom_range(1, 2) * 100 + $urandom_range(0, 19)));
      else
        pending_numbers.push_back(8'($urandom_range(0, 255)));
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_numbers.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("number_to_chinese_numeral_top test passed");
    end else begin
      $display("number_to_chinese_numeral_top test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("number_to_chinese_numeral_top test failed");
    $finish;
  end

endmodule
